@@ rtl/circle_point_generator_core_defines.svh @@
// Assertion macros used by the RTL core.
`ifndef CIRCLE_POINT_GENERATOR_CORE_DEFINES_SVH
`define CIRCLE_POINT_GENERATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPG_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpg assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpg assertion failed");

`endif

@@ rtl/cpg_pkg.sv @@
package cpg_pkg;

  localparam int MAX_POINTS = 64;
  localparam int FRAC_BITS  = 30;

  localparam logic [2:0] REG_INNER_RADIUS = 3'd0;
  localparam logic [2:0] REG_OUTER_RADIUS = 3'd1;
  localparam logic [2:0] REG_POINT_COUNT  = 3'd2;
  localparam logic [2:0] REG_START_COS    = 3'd3;
  localparam logic [2:0] REG_START_SIN    = 3'd4;
  localparam logic [2:0] REG_STEP_COS     = 3'd5;
  localparam logic [2:0] REG_STEP_SIN     = 3'd6;

  localparam logic [30:0] INNER_RADIUS_RESET = 31'd65536;
  localparam logic [30:0] OUTER_RADIUS_RESET = 31'd65536;
  localparam logic [6:0]  POINT_COUNT_RESET  = 7'd64;
  localparam logic signed [31:0] START_COS_RESET = 32'sd1073741824;
  localparam logic signed [31:0] START_SIN_RESET = 32'sd0;
  localparam logic signed [31:0] STEP_COS_RESET  = 32'sd1068571464;
  localparam logic signed [31:0] STEP_SIN_RESET  = 32'sd105245103;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef enum logic [3:0] {
    STEP_BX,
    STEP_BY,
    STEP_TX,
    STEP_TY,
    STEP_CC,
    STEP_CS,
    STEP_SC,
    STEP_SS,
    STEP_COMMIT
  } step_t;

endpackage

@@ rtl/circle_point_generator_core.sv @@
// For each center point transferred in, the core emits point_count results (1 to 64; zero
// is taken as 1 and larger counts as 64), each holding one point on the base circle and one
// on the tool circle at the same angle, plus the point index and a last flag. All products go
// through a single shared 33 by 33 bit multiplier, eight times per point (four radius terms
// and four rotation products), followed by a commit step. The input is ready only while no item
// is in progress; a held output result stalls the commit cycle.
`include "circle_point_generator_core_defines.svh"

module circle_point_generator_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] base_x,
  output logic signed [31:0] base_y,
  output logic signed [31:0] tool_x,
  output logic signed [31:0] tool_y,
  output logic [5:0]         ring_index,
  output logic               last
);
  import cpg_pkg::*;

  logic [30:0]        inner_radius;
  logic [30:0]        outer_radius;
  logic [6:0]         point_count;
  logic signed [31:0] start_cos;
  logic signed [31:0] start_sin;
  logic signed [31:0] step_cos;
  logic signed [31:0] step_sin;

  state_t state;
  state_t state_next;
  step_t  step;

  logic signed [31:0] cx;
  logic signed [31:0] cy;
  logic signed [31:0] cur_cos;
  logic signed [31:0] cur_sin;
  logic signed [31:0] nc_tmp;
  logic [5:0]         idx;

  logic signed [31:0] work_bx;
  logic signed [31:0] work_by;
  logic signed [31:0] work_tx;
  logic signed [31:0] work_ty;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod;
  logic signed [65:0] acc;

  logic signed [31:0] place_centre;
  logic signed [36:0] place_sum;
  logic signed [31:0] place_res;
  logic signed [66:0] rot_sum;
  logic signed [31:0] rot_res;

  logic [6:0] count_eff;
  logic       last_point;
  logic       in_xfer;
  logic       out_load;

  function automatic logic signed [31:0] sat37(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -37'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_radius <= INNER_RADIUS_RESET;
      outer_radius <= OUTER_RADIUS_RESET;
      point_count  <= POINT_COUNT_RESET;
      start_cos    <= START_COS_RESET;
      start_sin    <= START_SIN_RESET;
      step_cos     <= STEP_COS_RESET;
      step_sin     <= STEP_SIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INNER_RADIUS: inner_radius <= cfg_data[30:0];
        REG_OUTER_RADIUS: outer_radius <= cfg_data[30:0];
        REG_POINT_COUNT:  point_count  <= cfg_data[6:0];
        REG_START_COS:    start_cos    <= cfg_data;
        REG_START_SIN:    start_sin    <= cfg_data;
        REG_STEP_COS:     step_cos     <= cfg_data;
        REG_STEP_SIN:     step_sin     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (point_count == 7'd0) begin
      count_eff = 7'd1;
    end else if (point_count > 7'(MAX_POINTS)) begin
      count_eff = 7'(MAX_POINTS);
    end else begin
      count_eff = point_count;
    end
  end

  assign last_point = (({1'b0, idx} + 7'd1) == count_eff);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (out_load && last_point) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_RUN:  out_load = (step == STEP_COMMIT) && (!out_valid || out_ready);
      default: begin
      end
    endcase
  end

  assign in_xfer = in_valid && in_ready;

  always_comb begin
    case (step)
      STEP_BX: begin
        mul_a = {2'b00, inner_radius};
        mul_b = {cur_cos[31], cur_cos};
      end
      STEP_BY: begin
        mul_a = {2'b00, inner_radius};
        mul_b = {cur_sin[31], cur_sin};
      end
      STEP_TX: begin
        mul_a = {2'b00, outer_radius};
        mul_b = {cur_cos[31], cur_cos};
      end
      STEP_TY: begin
        mul_a = {2'b00, outer_radius};
        mul_b = {cur_sin[31], cur_sin};
      end
      STEP_CC: begin
        mul_a = {cur_cos[31], cur_cos};
        mul_b = {step_cos[31], step_cos};
      end
      STEP_CS: begin
        mul_a = {cur_sin[31], cur_sin};
        mul_b = {step_sin[31], step_sin};
      end
      STEP_SC: begin
        mul_a = {cur_sin[31], cur_sin};
        mul_b = {step_cos[31], step_cos};
      end
      STEP_SS: begin
        mul_a = {cur_cos[31], cur_cos};
        mul_b = {step_sin[31], step_sin};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // The product register holds the result of the previous step, so each arm below
  // finishes the term that was multiplied in the previous step.
  always_comb begin
    case (step)
      STEP_BY, STEP_TY: place_centre = cx;
      default:          place_centre = cy;
    endcase
  end

  assign place_sum = {{5{place_centre[31]}}, place_centre} + {prod[65], prod[65:FRAC_BITS]};
  assign place_res = sat37(place_sum);

  always_comb begin
    if (step == STEP_SC) begin
      rot_sum = {acc[65], acc} - {prod[65], prod};
    end else begin
      rot_sum = {acc[65], acc} + {prod[65], prod};
    end
  end

  assign rot_res = sat37(rot_sum[66:FRAC_BITS]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= STEP_BX;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_xfer) begin
        step <= STEP_BX;
        idx  <= '0;
      end else if (state == ST_RUN) begin
        if (step == STEP_COMMIT) begin
          if (out_load) begin
            step <= STEP_BX;
            idx  <= idx + 6'd1;
          end
        end else begin
          step <= step_t'(step + 4'd1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cx      <= center_x;
      cy      <= center_y;
      cur_cos <= start_cos;
      cur_sin <= start_sin;
    end else if (out_load) begin
      cur_cos <= nc_tmp;
      cur_sin <= rot_res;
    end
    if (state == ST_RUN && step != STEP_COMMIT) begin
      prod <= mul_a * mul_b;
    end
    case (step)
      STEP_BY: work_bx <= place_res;
      STEP_TX: work_by <= place_res;
      STEP_TY: work_tx <= place_res;
      STEP_CC: work_ty <= place_res;
      STEP_CS: acc     <= prod;
      STEP_SC: nc_tmp  <= rot_res;
      STEP_SS: acc     <= prod;
      default: begin
      end
    endcase
    if (out_load) begin
      base_x     <= work_bx;
      base_y     <= work_by;
      tool_x     <= work_tx;
      tool_y     <= work_ty;
      ring_index <= idx;
      last       <= last_point;
    end
  end

  `CPG_ASSERT_NEXT(a_accept_starts, clk, rst, in_xfer, state == ST_RUN && step == STEP_BX)
  `CPG_ASSERT_SAME(a_idle_at_first_step, clk, rst, in_ready, step == STEP_BX)
  `CPG_ASSERT_NEXT(a_steps_advance, clk, rst, state == ST_RUN && step != STEP_COMMIT,
                   state == ST_RUN && step != $past(step))
  `CPG_ASSERT_NEXT(a_last_ends_item, clk, rst, out_load && last_point,
                   in_ready && out_valid && last)

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import cpg_pkg::*;

  localparam int ITEMS_PER_SETTING = 60;
  localparam int RANDOM_SETTINGS   = 8;
  localparam int SETTLE_CYCLES     = 24;
  localparam int WATCHDOG_LIMIT    = 4000;
  localparam logic [2:0] REG_NONE  = 3'd7;
  localparam logic signed [31:0] Q30_ONE  = 32'sd1073741824;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] WORD_MIN = 32'sh80000000;
  localparam real TWO_PI = 6.28318530717958647692;

  typedef struct packed {
    logic signed [31:0] base_x;
    logic signed [31:0] base_y;
    logic signed [31:0] tool_x;
    logic signed [31:0] tool_y;
    logic [5:0]         ring_index;
    logic               last;
  } ring_point_t;

  typedef struct packed {
    int                 setting;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    bit                 typed;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
  } center_row_t;

  typedef enum logic [1:0] {
    DRAIN_FREE,
    DRAIN_COIN,
    DRAIN_SPARSE,
    DRAIN_BURSTY
  } drain_mode_t;

  // Rows with a typed result give the first point of the ring; the rest of the
  // ring, and every row without one, come from the predictor.
  localparam center_row_t DIR_ROWS [13] = '{
    '{0, 32'sd0, 32'sd0, 1'b1, 32'sd65536, 32'sd0, 32'sd65536, 32'sd0},
    '{0, WORD_MAX, WORD_MIN, 1'b1, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN},
    '{0, WORD_MIN, WORD_MAX, 1'b1, -32'sd2147418112, WORD_MAX, -32'sd2147418112, WORD_MAX},
    '{1, 32'sd0, 32'sd0, 1'b1, -32'sd2147483647, WORD_MAX, -32'sd1, 32'sd1},
    '{1, WORD_MIN, WORD_MAX, 1'b1, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX},
    '{1, WORD_MAX, WORD_MIN, 1'b1, 32'sd0, -32'sd1, 32'sd2147483646, -32'sd2147483647},
    '{1, 32'sh00012345, -32'sh0000abcd, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
    '{2, 32'sd0, 32'sd0, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
    '{2, 32'sh40000000, -32'sh40000000, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
    '{3, 32'sh00030000, 32'shfffb0000, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
    '{3, 32'sh7fff0000, 32'sh80010000, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
    '{4, 32'sd0, 32'sd0, 1'b1, 32'sd1, 32'sd0, 32'sd65536, 32'sd0},
    '{4, -32'sd7, 32'sd9, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}
  };

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] center_x = '0;
  logic signed [31:0] center_y = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] base_x;
  logic signed [31:0] base_y;
  logic signed [31:0] tool_x;
  logic signed [31:0] tool_y;
  logic [5:0]         ring_index;
  logic               last;

  logic [30:0]        m_inner;
  logic [30:0]        m_outer;
  logic [6:0]         m_count;
  logic signed [31:0] m_start_cos;
  logic signed [31:0] m_start_sin;
  logic signed [31:0] m_step_cos;
  logic signed [31:0] m_step_sin;

  ring_point_t ring_q[$];
  ring_point_t want_pt;
  int          mismatches = 0;
  int          centers_sent = 0;
  int          points_checked = 0;
  int          settings_used = 0;
  int          burst_left = 0;
  int          gap_odds = 0;
  int          quiet_cycles = 0;
  drain_mode_t drain_mode = DRAIN_FREE;
  int          drain_timer = 0;
  int          stall_left = 0;

  circle_point_generator_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .center_x   (center_x),
    .center_y   (center_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .base_x     (base_x),
    .base_y     (base_y),
    .tool_x     (tool_x),
    .tool_y     (tool_y),
    .ring_index (ring_index),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic signed [31:0] clamp_word(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return WORD_MAX;
    if (v < -66'sd2147483648) return WORD_MIN;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] circle_coord(input logic signed [31:0] centre,
                                                      input logic [30:0] radius,
                                                      input logic signed [31:0] c);
    logic signed [65:0] r_wide;
    logic signed [65:0] c_wide;
    logic signed [65:0] term;
    r_wide = {35'd0, radius};
    c_wide = c;
    term = (r_wide * c_wide) >>> FRAC_BITS;
    return clamp_word(term + centre);
  endfunction

  function automatic logic signed [31:0] rotate_mac(input logic signed [31:0] a, b, c, d,
                                                    input bit subtract);
    logic signed [65:0] aw, bw, cw, dw, sum;
    aw = a;
    bw = b;
    cw = c;
    dw = d;
    sum = subtract ? (aw * bw) - (cw * dw) : (aw * bw) + (cw * dw);
    return clamp_word(sum >>> FRAC_BITS);
  endfunction

  function automatic int ring_size(input logic [6:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_POINTS) return MAX_POINTS;
    return raw;
  endfunction

  task automatic predict_ring(input logic signed [31:0] cx, cy);
    int                 n;
    logic signed [31:0] cur_c;
    logic signed [31:0] cur_s;
    logic signed [31:0] nxt_c;
    ring_point_t        pt;
    n = ring_size(m_count);
    cur_c = m_start_cos;
    cur_s = m_start_sin;
    for (int k = 0; k < n; k++) begin
      pt.base_x = circle_coord(cx, m_inner, cur_c);
      pt.base_y = circle_coord(cy, m_inner, cur_s);
      pt.tool_x = circle_coord(cx, m_outer, cur_c);
      pt.tool_y = circle_coord(cy, m_outer, cur_s);
      pt.ring_index = 6'(k);
      pt.last = (k == n - 1);
      ring_q.push_back(pt);
      nxt_c = rotate_mac(cur_c, m_step_cos, cur_s, m_step_sin, 1'b1);
      cur_s = rotate_mac(cur_s, m_step_cos, cur_c, m_step_sin, 1'b0);
      cur_c = nxt_c;
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_INNER_RADIUS: m_inner = data[30:0];
      REG_OUTER_RADIUS: m_outer = data[30:0];
      REG_POINT_COUNT:  m_count = data[6:0];
      REG_START_COS:    m_start_cos = data;
      REG_START_SIN:    m_start_sin = data;
      REG_STEP_COS:     m_step_cos = data;
      REG_STEP_SIN:     m_step_sin = data;
      default: ;
    endcase
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (ring_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_center(input logic signed [31:0] x, y);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gap_odds != 0 && $urandom_range(0, 99) < gap_odds) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    center_x <= x;
    center_y <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_ring(x, y);
    centers_sent++;
  endtask

  task automatic apply_directed_setting(input int setting);
    case (setting)
      1: begin
        write_reg(REG_INNER_RADIUS, 32'h7fffffff);
        write_reg(REG_OUTER_RADIUS, 32'd1);
        write_reg(REG_POINT_COUNT, 32'd0);
        write_reg(REG_START_COS, -Q30_ONE);
        write_reg(REG_START_SIN, Q30_ONE);
        write_reg(REG_NONE, 32'hffffffff);
      end
      2: begin
        write_reg(REG_INNER_RADIUS, 32'd0);
        write_reg(REG_OUTER_RADIUS, 32'hffffffff);
        write_reg(REG_POINT_COUNT, 32'hffffff7f);
        write_reg(REG_START_COS, WORD_MAX);
        write_reg(REG_START_SIN, WORD_MIN);
        write_reg(REG_STEP_COS, WORD_MAX);
        write_reg(REG_STEP_SIN, WORD_MIN);
      end
      3: begin
        write_reg(REG_INNER_RADIUS, 32'h00030000);
        write_reg(REG_OUTER_RADIUS, 32'h00050000);
        write_reg(REG_POINT_COUNT, 32'd65);
        write_reg(REG_START_COS, 32'd0);
        write_reg(REG_START_SIN, Q30_ONE);
        write_reg(REG_STEP_COS, STEP_COS_RESET);
        write_reg(REG_STEP_SIN, -STEP_SIN_RESET);
        write_reg(REG_NONE, 32'h00000000);
      end
      default: begin
        write_reg(REG_INNER_RADIUS, 32'd1);
        write_reg(REG_OUTER_RADIUS, 32'h00010000);
        write_reg(REG_POINT_COUNT, 32'd2);
        write_reg(REG_START_COS, Q30_ONE);
        write_reg(REG_START_SIN, 32'd0);
        write_reg(REG_STEP_COS, -Q30_ONE);
        write_reg(REG_STEP_SIN, 32'd0);
      end
    endcase
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [31:0] random_radius();
    case ($urandom_range(0, 9))
      0: return $urandom & 32'h80000000;
      1: return 32'h7fffffff;
      2, 3, 4: return $urandom_range(1, 64 << 16);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] random_pair_value();
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 32'h80000000) - 32'h40000000;
    return $urandom;
  endfunction

  function automatic logic signed [31:0] random_coord();
    case ($urandom_range(0, 9))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2, 3: return $signed($urandom_range(0, 32'h1fffff)) - 32'sh100000;
      default: return $urandom;
    endcase
  endfunction

  task automatic randomize_setting();
    int          pick;
    int          n;
    logic [31:0] raw_count;
    real         start_ang;
    real         step_ang;
    write_reg(REG_INNER_RADIUS, random_radius());
    write_reg(REG_OUTER_RADIUS, random_radius());
    pick = $urandom_range(0, 19);
    if (pick == 0) raw_count = 0;
    else if (pick == 1) raw_count = 1;
    else if (pick < 4) raw_count = MAX_POINTS;
    else if (pick < 6) raw_count = $urandom_range(MAX_POINTS + 1, 127);
    else if (pick < 13) raw_count = $urandom_range(1, 8);
    else raw_count = $urandom_range(1, MAX_POINTS);
    if ($urandom_range(0, 3) == 0) raw_count = raw_count | ($urandom & 32'hffffff80);
    write_reg(REG_POINT_COUNT, raw_count);
    n = ring_size(m_count);
    if ($urandom_range(0, 4) != 0) begin
      start_ang = TWO_PI * $urandom_range(0, 9999) / 10000.0;
      step_ang = TWO_PI / n;
      if ($urandom_range(0, 3) == 0) step_ang = -step_ang;
      write_reg(REG_START_COS, $rtoi($cos(start_ang) * 1073741824.0));
      write_reg(REG_START_SIN, $rtoi($sin(start_ang) * 1073741824.0));
      write_reg(REG_STEP_COS, $rtoi($cos(step_ang) * 1073741824.0));
      write_reg(REG_STEP_SIN, $rtoi($sin(step_ang) * 1073741824.0));
    end else begin
      write_reg(REG_START_COS, random_pair_value());
      write_reg(REG_START_SIN, random_pair_value());
      write_reg(REG_STEP_COS, random_pair_value());
      write_reg(REG_STEP_SIN, random_pair_value());
    end
    if ($urandom_range(0, 3) == 0) write_reg(REG_NONE, $urandom);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (drain_timer == 0) begin
      drain_mode <= drain_mode_t'($urandom_range(0, 3));
      drain_timer <= $urandom_range(50, 400);
    end else begin
      drain_timer <= drain_timer - 1;
    end
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      case (drain_mode)
        DRAIN_FREE:   out_ready <= 1'b1;
        DRAIN_COIN:   out_ready <= $urandom_range(0, 1);
        DRAIN_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default: begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 29) == 0) stall_left <= $urandom_range(5, 40);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (ring_q.size() == 0) begin
        $error("Result transfer with nothing expected, ring_index %0d", ring_index);
        mismatches++;
      end else begin
        want_pt = ring_q.pop_front();
        check_field("base_x", want_pt.base_x, base_x);
        check_field("base_y", want_pt.base_y, base_y);
        check_field("tool_x", want_pt.tool_x, tool_x);
        check_field("tool_y", want_pt.tool_y, tool_y);
        check_field("ring_index", want_pt.ring_index, ring_index);
        check_field("last", want_pt.last, last);
      end
      points_checked++;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int                 row_setting;
    int                 first;
    center_row_t        row;
    ring_point_t        pt;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    m_inner = INNER_RADIUS_RESET;
    m_outer = OUTER_RADIUS_RESET;
    m_count = POINT_COUNT_RESET;
    m_start_cos = START_COS_RESET;
    m_start_sin = START_SIN_RESET;
    m_step_cos = STEP_COS_RESET;
    m_step_sin = STEP_SIN_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    settings_used = 1;
    row_setting = 0;
    gap_odds = 30;
    for (int i = 0; i < $size(DIR_ROWS); i++) begin
      row = DIR_ROWS[i];
      if (row.setting != row_setting) begin
        settle();
        apply_directed_setting(row.setting);
        row_setting = row.setting;
      end
      send_center(row.cx, row.cy);
      // The new ring is the tail of the queue; older points may have drained meanwhile.
      first = ring_q.size() - ring_size(m_count);
      if (row.typed) begin
        pt = ring_q[first];
        pt.base_x = row.bx;
        pt.base_y = row.by;
        pt.tool_x = row.tx;
        pt.tool_y = row.ty;
        ring_q[first] = pt;
      end
    end
    for (int s = 0; s < RANDOM_SETTINGS; s++) begin
      settle();
      randomize_setting();
      gap_odds = (s % 3 == 0) ? 0 : $urandom_range(10, 60);
      repeat (ITEMS_PER_SETTING) begin
        cx = random_coord();
        cy = random_coord();
        send_center(cx, cy);
      end
    end
    settle();
    $display("Checked %0d ring points from %0d center transfers under %0d register settings.",
             points_checked, centers_sent, settings_used);
    $display("Field mismatches: %0d", mismatches);
    if (mismatches == 0 && ring_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/cpg_pkg.sv
rtl/circle_point_generator_core.sv
tb/tb_top.sv
